// ===== design/bpitd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpitd_pkg
// Shared types, widths and constants of the binaural pan and ITD block.
// ----------------------------------------------------------------------------
package bpitd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_POSE_X = 2'd0,
    REG_POSE_Y = 2'd1,
    REG_POSE_Z = 2'd2,
    REG_POSE_W = 2'd3
  } cfg_reg_t;

  localparam logic signed [15:0] POSE_W_RESET = 16'sd16384;

  // Radicand widths of the radius and weight square root pipelines
  localparam int unsigned ROOT_RAD_W   = 64;
  localparam int unsigned WEIGHT_RAD_W = 34;
  // Divider: quotient bits and divisor width
  localparam int unsigned QUOT_W  = 17;
  localparam int unsigned DEN_W   = 32;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] TWO_Q16   = 18'd131072;
  localparam logic [28:0] ITD_K     = 29'd384829070;
  localparam logic [45:0] ITD_ROUND = 46'd2147483648;
  localparam logic [23:0] DELAY_MAX = 24'hFFFFFF;

  // Sideband carried through the lateral radius square root
  typedef struct packed {
    logic [30:0]        ax;
    logic               neg;
    logic               zero;
    logic [23:0]        base;
    logic signed [15:0] gain;
  } norm_sb_t;

  // Sideband carried through the divider
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic [23:0]        base;
    logic signed [15:0] gain;
  } div_sb_t;

  // Sideband carried through the left weight square root
  typedef struct packed {
    logic [45:0] itd_prod;
    logic [23:0] base;
    logic        neg;
    logic        nz;
  } dly_sb_t;

  // Sideband carried through the right weight square root
  typedef struct packed {
    logic        gneg;
    logic [16:0] gmag;
  } gain_sb_t;

endpackage

// ===== design/bpitd_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpitd_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bpitd_isqrt #(
  parameter int unsigned IN_W = bpitd_pkg::ROOT_RAD_W,
  parameter int unsigned SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      in_rad,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    out_root,
  output logic [SB_W-1:0]      out_sb
);

  localparam int unsigned STAGES = IN_W / 2;

  logic [STAGES-1:0] vld_r;
  logic [IN_W-1:0]   res_r [STAGES];
  logic [IN_W-1:0]   rem_r [STAGES-1];
  logic [SB_W-1:0]   sb_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * s);

    logic            vld_in;
    logic [IN_W-1:0] res_in;
    logic [IN_W-1:0] rem_in;
    logic [SB_W-1:0] sb_in;
    logic [IN_W:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign res_in = '0;
      assign rem_in = in_rad;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign res_in = res_r[s-1];
      assign rem_in = rem_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      res_r[s] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
      sb_r[s]  <= sb_in;
    end

    // Drop the remainder after the last bit
    if (s < STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? (rem_in - trial[IN_W-1:0]) : rem_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_root  = res_r[STAGES-1][IN_W/2-1:0];
  assign out_sb    = sb_r[STAGES-1];

endmodule

// ===== design/bpitd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpitd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The numerator must stay below the divisor times 2^Q_W.
// ----------------------------------------------------------------------------
module bpitd_div #(
  parameter int unsigned Q_W  = bpitd_pkg::QUOT_W,
  parameter int unsigned D_W  = bpitd_pkg::DEN_W,
  parameter int unsigned SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [Q_W+D_W-1:0]   in_num,
  input  logic [D_W-1:0]       in_den,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [Q_W-1:0]       out_quot,
  output logic [SB_W-1:0]      out_sb
);

  localparam int unsigned N_W    = Q_W + D_W;
  localparam int unsigned STAGES = Q_W;

  logic [STAGES-1:0] vld_r;
  logic [Q_W-1:0]    q_r   [STAGES];
  logic [N_W-1:0]    rem_r [STAGES-1];
  logic [D_W-1:0]    den_r [STAGES-1];
  logic [SB_W-1:0]   sb_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned K = Q_W - 1 - s;

    logic            vld_in;
    logic [Q_W-1:0]  q_in;
    logic [N_W-1:0]  rem_in;
    logic [D_W-1:0]  den_in;
    logic [SB_W-1:0] sb_in;
    logic [N_W-1:0]  sub;
    logic            ge;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign q_in   = '0;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign q_in   = q_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    assign sub = {{Q_W{1'b0}}, den_in} << K;
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      q_r[s]  <= q_in | ({{(Q_W-1){1'b0}}, ge} << K);
      sb_r[s] <= sb_in;
    end

    // Hold remainder and divisor only while bits remain
    if (s < STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? (rem_in - sub) : rem_in;
        den_r[s] <= den_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quot  = q_r[STAGES-1];
  assign out_sb    = sb_r[STAGES-1];

endmodule

// ===== design/binaural_pan_and_itd_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binaural_pan_and_itd_top
// Equal-power binaural panning with interaural time difference.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so one source direction, base delay
//   and gain can be issued in every cycle.
//   Result channel: out_valid strobes for exactly one cycle with the left
//   and right gains and delays; the receiver takes it at the end of that
//   cycle and cannot stall the block, so nothing here ever holds back.
//   Configuration: write the head-pose quaternion through cfg_we, cfg_addr
//   and cfg_wdata while no transaction is in flight.
//   Depth: the result of a transaction strobes on out_valid once it has
//   passed every stage. Throughput is one transaction per cycle. The depth is
//   set by the bit-per-stage pipelines: the 32-stage square root of the
//   lateral radius, the 17-stage divider for the sine and the 17-stage
//   square roots of the pan weights, plus 15 arithmetic stages.
//   Reset: rst_n (synchronous) empties the pipeline and loads the identity
//   pose (x = y = z = 0, w = 1.0 in Q1.14).
// ----------------------------------------------------------------------------
module binaural_pan_and_itd_top (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic [23:0]        in_base_delay,
  input  logic signed [15:0] in_source_gain,
  // result channel
  output logic               out_valid,
  output logic signed [15:0] out_left_gain,
  output logic signed [15:0] out_right_gain,
  output logic [23:0]        out_left_delay,
  output logic [23:0]        out_right_delay,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  localparam int unsigned RR_W = bpitd_pkg::ROOT_RAD_W;
  localparam int unsigned WR_W = bpitd_pkg::WEIGHT_RAD_W;
  localparam int unsigned Q_W  = bpitd_pkg::QUOT_W;
  localparam int unsigned D_W  = bpitd_pkg::DEN_W;

  // The pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Pose registers
  // --------------------------------------------------------------------------
  logic signed [15:0] pose_x_r, pose_y_r, pose_z_r, pose_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      pose_z_r <= '0;
      pose_w_r <= bpitd_pkg::POSE_W_RESET;
    end else if (cfg_we) begin
      unique case (bpitd_pkg::cfg_reg_t'(cfg_addr))
        bpitd_pkg::REG_POSE_X: pose_x_r <= cfg_wdata;
        bpitd_pkg::REG_POSE_Y: pose_y_r <= cfg_wdata;
        bpitd_pkg::REG_POSE_Z: pose_z_r <= cfg_wdata;
        bpitd_pkg::REG_POSE_W: pose_w_r <= cfg_wdata;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids for the arithmetic front end and back end
  // --------------------------------------------------------------------------
  logic a1_v_r, a2_v_r, a3_v_r, a4_v_r, a5_v_r, a6_v_r, a7_v_r, a8_v_r, a9_v_r;
  logic b1_v_r, e1_v_r, e2_v_r, f1_v_r, f2_v_r, f3_v_r;
  logic sq1_v, div_v, sqw_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0; a2_v_r <= 1'b0; a3_v_r <= 1'b0; a4_v_r <= 1'b0;
      a5_v_r <= 1'b0; a6_v_r <= 1'b0; a7_v_r <= 1'b0; a8_v_r <= 1'b0;
      a9_v_r <= 1'b0; b1_v_r <= 1'b0; e1_v_r <= 1'b0; e2_v_r <= 1'b0;
      f1_v_r <= 1'b0; f2_v_r <= 1'b0; f3_v_r <= 1'b0;
    end else begin
      a1_v_r <= accept;
      a2_v_r <= a1_v_r;
      a3_v_r <= a2_v_r;
      a4_v_r <= a3_v_r;
      a5_v_r <= a4_v_r;
      a6_v_r <= a5_v_r;
      a7_v_r <= a6_v_r;
      a8_v_r <= a7_v_r;
      a9_v_r <= a8_v_r;
      b1_v_r <= sq1_v;
      e1_v_r <= div_v;
      e2_v_r <= e1_v_r;
      f1_v_r <= sqw_v;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // A1: pairwise products of pose and direction, pose squares
  // --------------------------------------------------------------------------
  logic signed [31:0] a1_pxvx_r, a1_pyvy_r, a1_pzvz_r;
  logic signed [31:0] a1_pyvz_r, a1_pzvy_r, a1_pxvy_r, a1_pyvx_r;
  logic signed [31:0] a1_w2_r, a1_px2_r, a1_py2_r, a1_pz2_r;
  logic signed [15:0] a1_vx_r, a1_vz_r, a1_gain_r;
  logic [23:0]        a1_base_r;

  always_ff @(posedge clk) begin
    a1_pxvx_r <= pose_x_r * in_dir_x;
    a1_pyvy_r <= pose_y_r * in_dir_y;
    a1_pzvz_r <= pose_z_r * in_dir_z;
    a1_pyvz_r <= pose_y_r * in_dir_z;
    a1_pzvy_r <= pose_z_r * in_dir_y;
    a1_pxvy_r <= pose_x_r * in_dir_y;
    a1_pyvx_r <= pose_y_r * in_dir_x;
    a1_w2_r   <= pose_w_r * pose_w_r;
    a1_px2_r  <= pose_x_r * pose_x_r;
    a1_py2_r  <= pose_y_r * pose_y_r;
    a1_pz2_r  <= pose_z_r * pose_z_r;
    a1_vx_r   <= in_dir_x;
    a1_vz_r   <= in_dir_z;
    a1_base_r <= in_base_delay;
    a1_gain_r <= in_source_gain;
  end

  // --------------------------------------------------------------------------
  // A2: dot product p.v, w^2 - |p|^2 and the cross terms
  // --------------------------------------------------------------------------
  logic signed [32:0] a2_dot_r, a2_m_r, a2_cx_r, a2_cz_r;
  logic signed [15:0] a2_vx_r, a2_vz_r, a2_gain_r;
  logic [23:0]        a2_base_r;

  always_ff @(posedge clk) begin
    a2_dot_r  <= 33'(a1_pxvx_r) + 33'(a1_pyvy_r) + 33'(a1_pzvz_r);
    a2_m_r    <= 33'(a1_w2_r) - (33'(a1_px2_r) + 33'(a1_py2_r) + 33'(a1_pz2_r));
    a2_cx_r   <= 33'(a1_pyvz_r) - 33'(a1_pzvy_r);
    a2_cz_r   <= 33'(a1_pxvy_r) - 33'(a1_pyvx_r);
    a2_vx_r   <= a1_vx_r;
    a2_vz_r   <= a1_vz_r;
    a2_base_r <= a1_base_r;
    a2_gain_r <= a1_gain_r;
  end

  // --------------------------------------------------------------------------
  // A3: the three terms of hx and hz
  // --------------------------------------------------------------------------
  logic signed [48:0] a3_t1x_r, a3_t2x_r, a3_t3x_r;
  logic signed [48:0] a3_t1z_r, a3_t2z_r, a3_t3z_r;
  logic signed [15:0] a3_gain_r;
  logic [23:0]        a3_base_r;

  always_ff @(posedge clk) begin
    a3_t1x_r  <= a2_dot_r * pose_x_r;
    a3_t2x_r  <= a2_m_r * a2_vx_r;
    a3_t3x_r  <= a2_cx_r * pose_w_r;
    a3_t1z_r  <= a2_dot_r * pose_z_r;
    a3_t2z_r  <= a2_m_r * a2_vz_r;
    a3_t3z_r  <= a2_cz_r * pose_w_r;
    a3_base_r <= a2_base_r;
    a3_gain_r <= a2_gain_r;
  end

  // --------------------------------------------------------------------------
  // A4: head-space x and z
  // --------------------------------------------------------------------------
  logic signed [51:0] a4_hx_r, a4_hz_r;
  logic signed [15:0] a4_gain_r;
  logic [23:0]        a4_base_r;

  always_ff @(posedge clk) begin
    a4_hx_r   <= (52'(a3_t1x_r) <<< 1) + 52'(a3_t2x_r) - (52'(a3_t3x_r) <<< 1);
    a4_hz_r   <= (52'(a3_t1z_r) <<< 1) + 52'(a3_t2z_r) - (52'(a3_t3z_r) <<< 1);
    a4_base_r <= a3_base_r;
    a4_gain_r <= a3_gain_r;
  end

  // --------------------------------------------------------------------------
  // A5: magnitudes, sign of hx and the larger magnitude
  // --------------------------------------------------------------------------
  logic [50:0]        a5_ax, a5_az;
  logic [50:0]        a5_ax_r, a5_az_r, a5_mx_r;
  logic               a5_neg_r;
  logic signed [15:0] a5_gain_r;
  logic [23:0]        a5_base_r;

  assign a5_ax = a4_hx_r[51] ? 51'(-a4_hx_r) : a4_hx_r[50:0];
  assign a5_az = a4_hz_r[51] ? 51'(-a4_hz_r) : a4_hz_r[50:0];

  always_ff @(posedge clk) begin
    a5_ax_r   <= a5_ax;
    a5_az_r   <= a5_az;
    a5_mx_r   <= (a5_ax > a5_az) ? a5_ax : a5_az;
    a5_neg_r  <= a4_hx_r[51];
    a5_base_r <= a4_base_r;
    a5_gain_r <= a4_gain_r;
  end

  // --------------------------------------------------------------------------
  // A6: leading one of the larger magnitude
  // --------------------------------------------------------------------------
  logic [5:0]         a6_msb;
  logic [5:0]         a6_msb_r;
  logic [50:0]        a6_ax_r, a6_az_r;
  logic               a6_neg_r, a6_zero_r;
  logic signed [15:0] a6_gain_r;
  logic [23:0]        a6_base_r;

  always_comb begin
    a6_msb = '0;
    for (int i = 0; i < 51; i++) begin
      if (a5_mx_r[i]) a6_msb = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    a6_msb_r  <= a6_msb;
    a6_ax_r   <= a5_ax_r;
    a6_az_r   <= a5_az_r;
    a6_neg_r  <= a5_neg_r;
    a6_zero_r <= (a5_mx_r == '0);
    a6_base_r <= a5_base_r;
    a6_gain_r <= a5_gain_r;
  end

  // --------------------------------------------------------------------------
  // A7: normalize so the larger magnitude lies in [2^30, 2^31)
  // --------------------------------------------------------------------------
  logic               a7_right;
  logic [30:0]        a7_ax_r, a7_az_r;
  logic               a7_neg_r, a7_zero_r;
  logic signed [15:0] a7_gain_r;
  logic [23:0]        a7_base_r;

  assign a7_right = a6_msb_r > 6'd30;

  always_ff @(posedge clk) begin
    a7_ax_r   <= a7_right ? 31'(a6_ax_r >> (a6_msb_r - 6'd30))
                          : 31'(a6_ax_r << (6'd30 - a6_msb_r));
    a7_az_r   <= a7_right ? 31'(a6_az_r >> (a6_msb_r - 6'd30))
                          : 31'(a6_az_r << (6'd30 - a6_msb_r));
    a7_neg_r  <= a6_neg_r;
    a7_zero_r <= a6_zero_r;
    a7_base_r <= a6_base_r;
    a7_gain_r <= a6_gain_r;
  end

  // --------------------------------------------------------------------------
  // A8: squares; A9: radius squared
  // --------------------------------------------------------------------------
  logic [61:0]          a8_sqx_r, a8_sqz_r;
  bpitd_pkg::norm_sb_t  a8_sb_r, a9_sb_r;
  logic [RR_W-1:0]      a9_n_r;

  always_ff @(posedge clk) begin
    a8_sqx_r     <= a7_ax_r * a7_ax_r;
    a8_sqz_r     <= a7_az_r * a7_az_r;
    a8_sb_r.ax   <= a7_ax_r;
    a8_sb_r.neg  <= a7_neg_r;
    a8_sb_r.zero <= a7_zero_r;
    a8_sb_r.base <= a7_base_r;
    a8_sb_r.gain <= a7_gain_r;
    a9_n_r       <= RR_W'(a8_sqx_r) + RR_W'(a8_sqz_r);
    a9_sb_r      <= a8_sb_r;
  end

  // --------------------------------------------------------------------------
  // Radius: r = floor(sqrt(ax^2 + az^2))
  // --------------------------------------------------------------------------
  logic [RR_W/2-1:0]                  sq1_root;
  logic [$bits(bpitd_pkg::norm_sb_t)-1:0] sq1_sb;
  bpitd_pkg::norm_sb_t                sq1_sbs;

  bpitd_isqrt #(
    .IN_W (RR_W),
    .SB_W ($bits(bpitd_pkg::norm_sb_t))
  ) u_radius_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a9_v_r),
    .in_rad    (a9_n_r),
    .in_sb     (a9_sb_r),
    .out_valid (sq1_v),
    .out_root  (sq1_root),
    .out_sb    (sq1_sb)
  );

  assign sq1_sbs = bpitd_pkg::norm_sb_t'(sq1_sb);

  // --------------------------------------------------------------------------
  // B1: rounded numerator ax * 2^16 + r / 2
  // --------------------------------------------------------------------------
  logic [Q_W+D_W-1:0]   b1_num_r;
  logic [D_W-1:0]       b1_den_r;
  bpitd_pkg::div_sb_t   b1_sb_r;

  always_ff @(posedge clk) begin
    b1_num_r     <= (Q_W+D_W)'({sq1_sbs.ax, 16'd0}) + (Q_W+D_W)'(sq1_root >> 1);
    b1_den_r     <= D_W'(sq1_root);
    b1_sb_r.neg  <= sq1_sbs.neg;
    b1_sb_r.zero <= sq1_sbs.zero;
    b1_sb_r.base <= sq1_sbs.base;
    b1_sb_r.gain <= sq1_sbs.gain;
  end

  // --------------------------------------------------------------------------
  // |s| in Q16
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]                        div_q;
  logic [$bits(bpitd_pkg::div_sb_t)-1:0] div_sb;
  bpitd_pkg::div_sb_t                    div_sbs;

  bpitd_div #(
    .Q_W  (Q_W),
    .D_W  (D_W),
    .SB_W ($bits(bpitd_pkg::div_sb_t))
  ) u_sine_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b1_v_r),
    .in_num    (b1_num_r),
    .in_den    (b1_den_r),
    .in_sb     (b1_sb_r),
    .out_valid (div_v),
    .out_quot  (div_q),
    .out_sb    (div_sb)
  );

  assign div_sbs = bpitd_pkg::div_sb_t'(div_sb);

  // --------------------------------------------------------------------------
  // E1: clamp |s|, drop the sign of a zero sine, pan in Q16, gain magnitude
  // --------------------------------------------------------------------------
  logic [16:0]        e1_smag;
  logic               e1_negf;
  logic signed [16:0] e1_gext;
  logic [16:0]        e1_smag_r, e1_gmag_r;
  logic [17:0]        e1_p_r;
  logic               e1_neg_r, e1_gneg_r;
  logic [23:0]        e1_base_r;

  assign e1_smag = div_sbs.zero ? 17'd0
                 : ((div_q > bpitd_pkg::ONE_Q16) ? bpitd_pkg::ONE_Q16 : div_q);
  assign e1_negf = div_sbs.neg && (e1_smag != '0);
  assign e1_gext = 17'(div_sbs.gain);

  always_ff @(posedge clk) begin
    e1_smag_r <= e1_smag;
    e1_neg_r  <= e1_negf;
    e1_p_r    <= e1_negf ? (18'(bpitd_pkg::ONE_Q16) - 18'(e1_smag))
                         : (18'(bpitd_pkg::ONE_Q16) + 18'(e1_smag));
    e1_gneg_r <= div_sbs.gain[15];
    e1_gmag_r <= div_sbs.gain[15] ? 17'(-e1_gext) : 17'(e1_gext);
    e1_base_r <= div_sbs.base;
  end

  // --------------------------------------------------------------------------
  // E2: ITD product and the weight radicands
  // --------------------------------------------------------------------------
  logic [WR_W-1:0]     e2_rr_r, e2_rl_r;
  bpitd_pkg::dly_sb_t  e2_dsb_r;
  bpitd_pkg::gain_sb_t e2_gsb_r;

  always_ff @(posedge clk) begin
    e2_rr_r           <= WR_W'({e1_p_r, 15'd0});
    e2_rl_r           <= WR_W'({bpitd_pkg::TWO_Q16 - e1_p_r, 15'd0});
    e2_dsb_r.itd_prod <= 46'(e1_smag_r) * 46'(bpitd_pkg::ITD_K);
    e2_dsb_r.base     <= e1_base_r;
    e2_dsb_r.neg      <= e1_neg_r;
    e2_dsb_r.nz       <= (e1_smag_r != '0);
    e2_gsb_r.gneg     <= e1_gneg_r;
    e2_gsb_r.gmag     <= e1_gmag_r;
  end

  // --------------------------------------------------------------------------
  // Equal-power weights in Q16
  // --------------------------------------------------------------------------
  logic [WR_W/2-1:0]                      wl_root, wr_root;
  logic [$bits(bpitd_pkg::dly_sb_t)-1:0]  wl_sb;
  logic [$bits(bpitd_pkg::gain_sb_t)-1:0] wr_sb;
  bpitd_pkg::dly_sb_t                     wl_sbs;
  bpitd_pkg::gain_sb_t                    wr_sbs;

  bpitd_isqrt #(
    .IN_W (WR_W),
    .SB_W ($bits(bpitd_pkg::dly_sb_t))
  ) u_left_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e2_v_r),
    .in_rad    (e2_rl_r),
    .in_sb     (e2_dsb_r),
    .out_valid (sqw_v),
    .out_root  (wl_root),
    .out_sb    (wl_sb)
  );

  // Runs in lockstep with the left weight; its valid is the same
  bpitd_isqrt #(
    .IN_W (WR_W),
    .SB_W ($bits(bpitd_pkg::gain_sb_t))
  ) u_right_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e2_v_r),
    .in_rad    (e2_rr_r),
    .in_sb     (e2_gsb_r),
    .out_valid (),
    .out_root  (wr_root),
    .out_sb    (wr_sb)
  );

  assign wl_sbs = bpitd_pkg::dly_sb_t'(wl_sb);
  assign wr_sbs = bpitd_pkg::gain_sb_t'(wr_sb);

  // --------------------------------------------------------------------------
  // F1: gain products and the rounded ITD
  // --------------------------------------------------------------------------
  logic [33:0] f1_pl_r, f1_pr_r;
  logic [13:0] f1_itd_r;
  logic [23:0] f1_base_r;
  logic        f1_neg_r, f1_nz_r, f1_gneg_r;

  always_ff @(posedge clk) begin
    f1_pl_r   <= 34'(wr_sbs.gmag) * 34'(wl_root);
    f1_pr_r   <= 34'(wr_sbs.gmag) * 34'(wr_root);
    f1_itd_r  <= 14'((wl_sbs.itd_prod + bpitd_pkg::ITD_ROUND) >> 32);
    f1_base_r <= wl_sbs.base;
    f1_neg_r  <= wl_sbs.neg;
    f1_nz_r   <= wl_sbs.nz;
    f1_gneg_r <= wr_sbs.gneg;
  end

  // --------------------------------------------------------------------------
  // F2: round gain magnitudes, add the ITD to the far ear
  // --------------------------------------------------------------------------
  logic [16:0] f2_ml_r, f2_mr_r;
  logic [24:0] f2_ld_r, f2_rd_r;
  logic        f2_gneg_r;

  always_ff @(posedge clk) begin
    f2_ml_r   <= 17'((f1_pl_r + 34'd32768) >> 16);
    f2_mr_r   <= 17'((f1_pr_r + 34'd32768) >> 16);
    f2_ld_r   <= 25'(f1_base_r) + ((f1_nz_r && !f1_neg_r) ? 25'(f1_itd_r) : 25'd0);
    f2_rd_r   <= 25'(f1_base_r) + ((f1_nz_r && f1_neg_r) ? 25'(f1_itd_r) : 25'd0);
    f2_gneg_r <= f1_gneg_r;
  end

  // --------------------------------------------------------------------------
  // F3: apply the gain sign, saturate the delays, drive the result
  // --------------------------------------------------------------------------
  logic [15:0] f3_lg_r, f3_rg_r;
  logic [23:0] f3_ld_r, f3_rd_r;

  always_ff @(posedge clk) begin
    f3_lg_r <= 16'(f2_gneg_r ? (17'd0 - f2_ml_r) : f2_ml_r);
    f3_rg_r <= 16'(f2_gneg_r ? (17'd0 - f2_mr_r) : f2_mr_r);
    f3_ld_r <= f2_ld_r[24] ? bpitd_pkg::DELAY_MAX : f2_ld_r[23:0];
    f3_rd_r <= f2_rd_r[24] ? bpitd_pkg::DELAY_MAX : f2_rd_r[23:0];
  end

  assign out_valid       = f3_v_r;
  assign out_left_gain   = f3_lg_r;
  assign out_right_gain  = f3_rg_r;
  assign out_left_delay  = f3_ld_r;
  assign out_right_delay = f3_rd_r;

endmodule
